### hdl/ccmd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccmd_pkg
// Shared types, codes and constants of the character lcd command engine.
// ---------------------------------------------------------------------------
package ccmd_pkg;

  // default geometry
  localparam int CCMD_COLUMNS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ADDR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT_ADDR = 1'd1;
  localparam logic [6:0] DISPLAY_ADDR_RST   = 7'(8'h7c >> 1);
  localparam logic [6:0] BACKLIGHT_ADDR_RST = 7'(8'hc4 >> 1);

  // command opcodes
  typedef enum logic [3:0] {
    OP_TEXT    = 4'd0,
    OP_RAW     = 4'd1,
    OP_ROW     = 4'd2,
    OP_COL     = 4'd3,
    OP_CLEAR   = 4'd4,
    OP_DISPLAY = 4'd5,
    OP_ENTRY   = 4'd6,
    OP_COLOR   = 4'd7,
    OP_SCROLL  = 4'd8
  } op_t;

  // color channels
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // control bytes and lcd commands
  localparam logic [7:0] CMD_CTRL      = 8'h80;
  localparam logic [7:0] DATA_CTRL     = 8'h40;
  localparam logic [7:0] ROW0_BASE     = 8'h80;
  localparam logic [7:0] ROW1_BASE     = 8'hc0;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h04;
  localparam logic [7:0] CMD_DISPLAY   = 8'h08;
  localparam logic [7:0] CMD_SHIFT     = 8'h10;
  localparam logic [7:0] SHIFT_DISPLAY = 8'h08;
  localparam logic [7:0] SHIFT_RIGHT   = 8'h04;
  localparam logic [7:0] REG_RED       = 8'h04;
  localparam logic [7:0] REG_GREEN     = 8'h03;
  localparam logic [7:0] REG_BLUE      = 8'h02;
  localparam logic [7:0] NEWLINE_CHAR  = 8'h0a;

  // reset values of the mode bits
  localparam logic [1:0] ENTRY_RST   = 2'b10;
  localparam logic [2:0] DISPLAY_RST = 3'b100;

  // one bus write
  typedef struct packed {
    logic [6:0] bus_addr;
    logic [7:0] reg_addr;
    logic [7:0] data_byte;
    logic [4:0] cells_left;
    logic       display_full;
    logic       last;
  } wr_word_t;

  // writes produced by one command
  typedef struct packed {
    logic [1:0] cnt;
    wr_word_t   w0;
    wr_word_t   w1;
  } step_res_t;

endpackage

### hdl/ccmd_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccmd_core
// Cursor and mode state with the command decode that turns one command
// into up to two bus writes.
// ---------------------------------------------------------------------------
module ccmd_core #(
  parameter int COLUMNS = ccmd_pkg::CCMD_COLUMNS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [3:0]          opcode,
  input  logic [7:0]          value,
  input  logic [1:0]          channel,
  input  logic [6:0]          disp_addr,
  input  logic [6:0]          bl_addr,
  output ccmd_pkg::step_res_t res
);
  import ccmd_pkg::*;

  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int CW    = $clog2(2 * COLUMNS) + 1;
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [COL_W:0]   COL_LAST1 = (COL_W + 1)'(COLUMNS - 1);
  localparam logic [7:0]       COL_MAX   = 8'(COLUMNS);
  localparam logic [CW-1:0]    CNT_COLS  = CW'(COLUMNS);
  localparam logic [CW-1:0]    CNT_LAST  = CW'(COLUMNS - 1);
  localparam logic [CW-1:0]    CNT_FULL  = CW'(2 * COLUMNS - 1);
  localparam logic [CW-1:0]    CNT_SAT   = CW'(31);

  logic             row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [1:0]       entry_r, entry_nxt;
  logic [2:0]       disp_r, disp_nxt;

  logic             rtl, ent_shift, emit_pos;
  logic [COL_W:0]   col_p1;
  logic [CW-1:0]    count;
  logic [4:0]       cells;
  logic             full;

  function automatic logic [7:0] pos_byte(input logic row, input logic [COL_W-1:0] col);
    pos_byte = (row ? ROW1_BASE : ROW0_BASE) | 8'(col);
  endfunction

  function automatic wr_word_t mk_word(input logic [6:0] bus, input logic [7:0] reg_a,
                                       input logic [7:0] data, input logic [4:0] cl,
                                       input logic fl);
    wr_word_t w;
    w.bus_addr     = bus;
    w.reg_addr     = reg_a;
    w.data_byte    = data;
    w.cells_left   = cl;
    w.display_full = fl;
    w.last         = 1'b0;
    mk_word = w;
  endfunction

  assign rtl       = ~entry_r[1];
  assign ent_shift = entry_r[0];
  assign col_p1    = {1'b0, col_r} + (COL_W + 1)'(1);

  // cells left in writing direction from the updated cursor
  always_comb begin
    if (rtl) begin
      count = CW'(col_nxt) + (row_nxt ? CNT_COLS : '0);
    end else begin
      count = (row_nxt ? '0 : CNT_COLS) + (CNT_LAST - CW'(col_nxt));
    end
    cells = (count > CNT_SAT) ? 5'd31 : count[4:0];
    full  = (count >= CNT_FULL);
  end

  // command decode and cursor update
  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    entry_nxt = entry_r;
    disp_nxt  = disp_r;
    emit_pos  = 1'b0;
    res.cnt   = 2'd0;
    res.w0    = mk_word(disp_addr, CMD_CTRL, 8'h00, 5'd0, 1'b0);
    res.w1    = mk_word(disp_addr, CMD_CTRL, 8'h00, 5'd0, 1'b0);
    unique case (opcode)
      OP_TEXT: begin
        if (value == NEWLINE_CHAR) begin
          row_nxt = 1'b1;
          col_nxt = rtl ? COL_LAST : '0;
          if (!ent_shift) begin
            res.cnt = 2'd1;
            res.w0  = mk_word(disp_addr, CMD_CTRL, pos_byte(1'b1, col_nxt), cells, full);
          end
        end else if (ent_shift) begin
          res.cnt = 2'd1;
          res.w0  = mk_word(disp_addr, DATA_CTRL, value, 5'd0, 1'b0);
        end else begin
          if (rtl) begin
            if (col_r == '0) begin
              if (!row_r) begin
                row_nxt  = 1'b1;
                col_nxt  = COL_LAST;
                emit_pos = 1'b1;
              end
            end else begin
              col_nxt = col_r - COL_W'(1);
            end
          end else begin
            if (col_p1 > COL_LAST1) begin
              if (!row_r) begin
                row_nxt  = 1'b1;
                col_nxt  = '0;
                emit_pos = 1'b1;
              end else begin
                col_nxt = COL_LAST;
              end
            end else begin
              col_nxt = col_p1[COL_W-1:0];
            end
          end
          res.w0 = mk_word(disp_addr, DATA_CTRL, value, cells, full);
          res.w1 = mk_word(disp_addr, CMD_CTRL, pos_byte(row_nxt, col_nxt), cells, full);
          res.cnt = emit_pos ? 2'd2 : 2'd1;
        end
      end
      OP_RAW: begin
        res.cnt = 2'd1;
        res.w0  = mk_word(disp_addr, DATA_CTRL, value, 5'd0, 1'b0);
      end
      OP_ROW: begin
        if (value <= 8'd1) begin
          row_nxt = value[0];
          res.cnt = 2'd1;
          res.w0  = mk_word(disp_addr, CMD_CTRL, pos_byte(value[0], col_r), 5'd0, 1'b0);
        end
      end
      OP_COL: begin
        if (value <= COL_MAX) begin
          col_nxt = value[COL_W-1:0];
          res.cnt = 2'd1;
          res.w0  = mk_word(disp_addr, CMD_CTRL, pos_byte(row_r, value[COL_W-1:0]),
                            5'd0, 1'b0);
        end
      end
      OP_CLEAR: begin
        row_nxt = 1'b0;
        col_nxt = '0;
        res.cnt = 2'd1;
        res.w0  = mk_word(disp_addr, CMD_CTRL, CMD_CLEAR, 5'd0, 1'b0);
      end
      OP_DISPLAY: begin
        disp_nxt = value[2:0];
        res.cnt  = 2'd1;
        res.w0   = mk_word(disp_addr, CMD_CTRL, CMD_DISPLAY | {5'd0, value[2:0]}, 5'd0, 1'b0);
      end
      OP_ENTRY: begin
        entry_nxt = value[1:0];
        res.cnt   = 2'd1;
        res.w0    = mk_word(disp_addr, CMD_CTRL, CMD_ENTRY | {6'd0, value[1:0]}, 5'd0, 1'b0);
      end
      OP_COLOR: begin
        unique case (channel)
          CH_RED: begin
            res.cnt = 2'd1;
            res.w0  = mk_word(bl_addr, REG_RED, value, 5'd0, 1'b0);
          end
          CH_GREEN: begin
            res.cnt = 2'd1;
            res.w0  = mk_word(bl_addr, REG_GREEN, value, 5'd0, 1'b0);
          end
          CH_BLUE: begin
            res.cnt = 2'd1;
            res.w0  = mk_word(bl_addr, REG_BLUE, value, 5'd0, 1'b0);
          end
          default: begin
            res.cnt = 2'd0;
          end
        endcase
      end
      OP_SCROLL: begin
        res.cnt = 2'd1;
        res.w0  = mk_word(disp_addr, CMD_CTRL,
                          CMD_SHIFT | SHIFT_DISPLAY | (value[0] ? SHIFT_RIGHT : 8'h00),
                          5'd0, 1'b0);
      end
      default: begin
        res.cnt = 2'd0;
      end
    endcase
    // flag the final write of the command
    res.w0.last = (res.cnt == 2'd1);
    res.w1.last = 1'b1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= 1'b0;
      col_r   <= '0;
      entry_r <= ENTRY_RST;
      disp_r  <= DISPLAY_RST;
    end else if (step_en) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      entry_r <= entry_nxt;
      disp_r  <= disp_nxt;
    end
  end

endmodule

### hdl/ccmd_out_buf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccmd_out_buf
// Output register with one pending slot for the second write of a command.
// ---------------------------------------------------------------------------
module ccmd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ccmd_pkg::step_res_t res,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output ccmd_pkg::wr_word_t  out_word
);
  import ccmd_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  logic     pend_valid_r, pend_valid_nxt;
  wr_word_t out_word_r, out_word_nxt;
  wr_word_t pend_word_r, pend_word_nxt;
  logic     take;

  assign take      = out_valid_r & out_ready;
  assign room      = ~pend_valid_r & (~out_valid_r | out_ready);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // slot update: new command words, or shift the pending word forward
  always_comb begin
    out_valid_nxt  = out_valid_r;
    pend_valid_nxt = pend_valid_r;
    out_word_nxt   = out_word_r;
    pend_word_nxt  = pend_word_r;
    if (load && res.cnt != 2'd0) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = res.w0;
      pend_valid_nxt = (res.cnt == 2'd2);
      pend_word_nxt  = res.w1;
    end else if (take) begin
      out_valid_nxt  = pend_valid_r;
      out_word_nxt   = pend_word_r;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    pend_word_r <= pend_word_nxt;
  end

endmodule

### hdl/char_lcd_cursor_command_engine_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_cursor_command_engine_top
// Command engine for a two-row character lcd and its rgb backlight chip.
// ---------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_ channel (opcode, argument, channel) with
//   valid/ready. Each command yields zero, one or two bus register writes
//   on the out_ channel, one word per handshake, out_last on the final one.
//   The cfg_ port sets the display and backlight bus addresses; write it
//   only while no command is in flight.
// Pipeline:
//   A command accepted on in_ is held in the input register, decoded
//   combinationally, and its first word is loaded into the output register
//   once the output buffer has room. A command that yields two writes keeps
//   its second word in the pending slot, and the next command waits until
//   the single output port has drained it.
// Reset:
//   rst_n low clears both channels, homes the cursor, sets left-to-right
//   entry with autoscroll off, display on, and restores the bus addresses.
// Stall:
//   While out_ready is low the output word holds; the input register
//   keeps one command and in_ready drops once it cannot be decoded.
// ---------------------------------------------------------------------------
module char_lcd_cursor_command_engine_top #(
  parameter int COLUMNS = ccmd_pkg::CCMD_COLUMNS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ccmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [3:0]                     in_opcode,
  input  logic [7:0]                     in_arg,
  input  logic [1:0]                     in_channel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [6:0]                     out_bus_addr,
  output logic [7:0]                     out_reg_addr,
  output logic [7:0]                     out_data_byte,
  output logic [4:0]                     out_cells_left,
  output logic                           out_display_full,
  output logic                           out_last
);
  import ccmd_pkg::*;

  logic       in_valid_r;
  logic [3:0] opcode_r;
  logic [7:0] value_r;
  logic [1:0] channel_r;
  logic [6:0] disp_addr_r;
  logic [6:0] bl_addr_r;
  logic       room, step_en;
  step_res_t  res;
  wr_word_t   out_word;

  assign step_en  = in_valid_r & room;
  assign in_ready = ~in_valid_r | step_en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_addr_r <= DISPLAY_ADDR_RST;
      bl_addr_r   <= BACKLIGHT_ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISPLAY_ADDR:   disp_addr_r <= cfg_wdata;
        CFG_BACKLIGHT_ADDR: bl_addr_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opcode_r  <= in_opcode;
      value_r   <= in_arg;
      channel_r <= in_channel;
    end
  end

  ccmd_core #(
    .COLUMNS(COLUMNS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .opcode   (opcode_r),
    .value    (value_r),
    .channel  (channel_r),
    .disp_addr(disp_addr_r),
    .bl_addr  (bl_addr_r),
    .res      (res)
  );

  ccmd_out_buf u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step_en),
    .res      (res),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  assign out_bus_addr     = out_word.bus_addr;
  assign out_reg_addr     = out_word.reg_addr;
  assign out_data_byte    = out_word.data_byte;
  assign out_cells_left   = out_word.cells_left;
  assign out_display_full = out_word.display_full;
  assign out_last         = out_word.last;

endmodule

### hdl/ccmd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccmd_checker
// Port-level checks of the command engine, bound to the top level.
// ---------------------------------------------------------------------------
module ccmd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_bus_addr,
  input logic [7:0] out_reg_addr,
  input logic [7:0] out_data_byte,
  input logic [4:0] out_cells_left,
  input logic       out_display_full,
  input logic       out_last
);
  import ccmd_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte)
      && $stable(out_reg_addr) && $stable(out_bus_addr) && $stable(out_last))
    else $error("output word changed while stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // the second write of a command follows right after the first
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second write of a command did not follow");

  // backlight writes carry no cursor status
  a_color_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_addr != CMD_CTRL && out_reg_addr != DATA_CTRL
      |-> out_cells_left == 5'd0 && !out_display_full)
    else $error("cursor status on a backlight write");

endmodule

bind char_lcd_cursor_command_engine_top ccmd_checker u_ccmd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_bus_addr    (out_bus_addr),
  .out_reg_addr    (out_reg_addr),
  .out_data_byte   (out_data_byte),
  .out_cells_left  (out_cells_left),
  .out_display_full(out_display_full),
  .out_last        (out_last)
);
